// ===== rtl/b64d_pkg.sv =====
// Package for the base64 stream decoder: item types, status codes,
// quartet phase encoding and the alphabet lookup. No dependencies.
package b64d_pkg;

    localparam int CHAR_W  = 8;
    localparam int SEXT_W  = 6;
    localparam int COUNT_W = 16;
    localparam int STAT_W  = 2;
    localparam int Q_DEPTH = 2;

    localparam logic [CHAR_W-1:0] PAD_CHAR = 8'd61;

    localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
    localparam logic [STAT_W-1:0] STAT_SHORT      = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD_LENGTH = 2'd2;

    typedef enum logic [2:0] {
        PH_0   = 3'd0,
        PH_1   = 3'd1,
        PH_2   = 3'd2,
        PH_3   = 3'd3,
        PH_PAD = 3'd4
    } b64d_phase_t;

    // Classified character as it travels from the front to the back.
    typedef struct packed {
        logic [SEXT_W-1:0] sextet;
        logic              bad;
        logic              pad;
        logic              last;
    } b64d_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0]  out_byte;
        logic               byte_valid;
        logic               done_res;
        logic [STAT_W-1:0]  status;
        logic [COUNT_W-1:0] decoded_count;
    } b64d_result_t;

    typedef struct packed {
        logic [SEXT_W-1:0] sextet;
        logic              bad;
    } b64d_lookup_t;

    function automatic b64d_lookup_t sextet_of(input logic [CHAR_W-1:0] c);
        b64d_lookup_t r;
        r.bad    = 1'b0;
        r.sextet = '0;
        case (c) inside
            [8'd65:8'd90]:  r.sextet = SEXT_W'(c - 8'd65);
            [8'd97:8'd122]: r.sextet = SEXT_W'(c - 8'd71);
            [8'd48:8'd57]:  r.sextet = SEXT_W'(c + 8'd4);
            8'd43:          r.sextet = 6'd62;
            8'd47:          r.sextet = 6'd63;
            default:        r.bad    = 1'b1;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/b64d_front.sv =====
// Front end of the base64 stream decoder: input handshake and character
// classification into queue items. Depends on b64d_pkg.
module b64d_front (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [b64d_pkg::CHAR_W-1:0]   s_tdata,   // [7:0] char_in
    input  logic                          s_tlast,   // last_char
    input  logic                          q_full,
    output logic                          q_push,
    output b64d_pkg::b64d_item_t          q_item
);

    b64d_pkg::b64d_lookup_t look;

    always_comb begin
        look          = b64d_pkg::sextet_of(s_tdata);
        q_item.sextet = look.sextet;
        q_item.bad    = look.bad;
        q_item.pad    = (s_tdata == b64d_pkg::PAD_CHAR);
        q_item.last   = s_tlast;
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

endmodule

// ===== rtl/b64d_queue.sv =====
// Two-entry queue of classified characters between front and back.
// Depends on b64d_pkg.
module b64d_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  b64d_pkg::b64d_item_t push_item,
    input  logic                 pop,
    output b64d_pkg::b64d_item_t pop_item,
    output logic                 full,
    output logic                 empty
);

    localparam int PTR_W = (b64d_pkg::Q_DEPTH > 1) ? $clog2(b64d_pkg::Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(b64d_pkg::Q_DEPTH + 1);

    b64d_pkg::b64d_item_t mem [b64d_pkg::Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == CNT_W'(b64d_pkg::Q_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_item = mem[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(b64d_pkg::Q_DEPTH - 1)) ? '0
                                                                            : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(b64d_pkg::Q_DEPTH - 1)) ? '0
                                                                            : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/b64d_back.sv =====
// Back end of the base64 stream decoder: quartet state machine, byte
// assembly, status and the output register. Depends on b64d_pkg.
module b64d_back #(
    parameter logic [15:0] BYTE_CAP = 16'hFFFF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_empty,
    input  b64d_pkg::b64d_item_t   q_item,
    output logic                   q_pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output b64d_pkg::b64d_result_t out_res
);

    b64d_pkg::b64d_phase_t phase_reg, phase_next;
    logic [b64d_pkg::SEXT_W-1:0]  held_reg, held_next;
    logic                         halted_reg, halted_next;
    logic                         short_reg, short_next;
    logic [1:0]                   len_reg, len_next;
    logic [b64d_pkg::COUNT_W-1:0] count_reg, count_next;

    logic                         out_valid_reg;
    b64d_pkg::b64d_result_t       out_res_reg, res_next;

    logic                         emit;
    logic [b64d_pkg::CHAR_W-1:0]  byte_val;
    logic                         halt_now;
    logic                         short_now;

    assign q_pop     = !q_empty && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    // Next state of the quartet sequencer.
    always_comb begin
        phase_next = phase_reg;
        halt_now   = 1'b0;
        short_now  = 1'b0;
        if (!halted_reg) begin
            case (phase_reg)
                b64d_pkg::PH_0: begin
                    if (q_item.bad) begin
                        halt_now  = 1'b1;
                        short_now = 1'b1;
                    end else begin
                        phase_next = b64d_pkg::PH_1;
                    end
                end
                b64d_pkg::PH_1: begin
                    if (q_item.bad) begin
                        halt_now  = 1'b1;
                        short_now = 1'b1;
                    end else begin
                        phase_next = b64d_pkg::PH_2;
                    end
                end
                b64d_pkg::PH_2: begin
                    if (q_item.pad) begin
                        phase_next = b64d_pkg::PH_PAD;
                    end else if (q_item.bad) begin
                        halt_now  = 1'b1;
                        short_now = 1'b1;
                    end else begin
                        phase_next = b64d_pkg::PH_3;
                    end
                end
                b64d_pkg::PH_3: begin
                    if (q_item.pad || q_item.bad) begin
                        halt_now  = 1'b1;
                        short_now = !q_item.last;
                    end else begin
                        phase_next = b64d_pkg::PH_0;
                    end
                end
                b64d_pkg::PH_PAD: begin
                    halt_now  = 1'b1;
                    short_now = !q_item.pad || !q_item.last;
                end
                default: begin
                    halt_now  = 1'b1;
                    short_now = 1'b1;
                end
            endcase
        end
    end

    // Byte assembly for the current phase.
    always_comb begin
        emit     = 1'b0;
        byte_val = '0;
        if (!halted_reg && !q_item.bad) begin
            case (phase_reg)
                b64d_pkg::PH_1: begin
                    emit     = 1'b1;
                    byte_val = {held_reg, q_item.sextet[5:4]};
                end
                b64d_pkg::PH_2: begin
                    emit     = !q_item.pad;
                    byte_val = q_item.pad ? '0 : {held_reg[3:0], q_item.sextet[5:2]};
                end
                b64d_pkg::PH_3: begin
                    emit     = !q_item.pad;
                    byte_val = q_item.pad ? '0 : {held_reg[1:0], q_item.sextet};
                end
                default: begin
                    emit     = 1'b0;
                    byte_val = '0;
                end
            endcase
        end
    end

    // Running totals and the result for this character.
    always_comb begin
        held_next   = held_reg;
        halted_next = halted_reg || halt_now;
        short_next  = short_reg || short_now;
        len_next    = len_reg + 2'd1;
        count_next  = count_reg;
        if (!halted_reg && !q_item.bad && phase_reg != b64d_pkg::PH_3
                && phase_reg != b64d_pkg::PH_PAD) begin
            held_next = q_item.sextet;
        end
        if (emit && count_reg < BYTE_CAP) begin
            count_next = count_reg + 1'b1;
        end

        res_next.out_byte      = byte_val;
        res_next.byte_valid    = emit;
        res_next.done_res      = q_item.last;
        res_next.status        = b64d_pkg::STAT_OK;
        res_next.decoded_count = '0;
        if (q_item.last) begin
            if (len_next != 2'd0) begin
                res_next.status = b64d_pkg::STAT_BAD_LENGTH;
            end else begin
                res_next.status        = short_next ? b64d_pkg::STAT_SHORT : b64d_pkg::STAT_OK;
                res_next.decoded_count = count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= b64d_pkg::PH_0;
            held_reg      <= '0;
            halted_reg    <= 1'b0;
            short_reg     <= 1'b0;
            len_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                out_valid_reg <= 1'b1;
                if (q_item.last) begin
                    // The final character clears the string state.
                    phase_reg  <= b64d_pkg::PH_0;
                    held_reg   <= '0;
                    halted_reg <= 1'b0;
                    short_reg  <= 1'b0;
                    len_reg    <= '0;
                    count_reg  <= '0;
                end else begin
                    phase_reg  <= phase_next;
                    held_reg   <= held_next;
                    halted_reg <= halted_next;
                    short_reg  <= short_next;
                    len_reg    <= len_next;
                    count_reg  <= count_next;
                end
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_res_reg <= res_next;
        end
    end

    a_halt_no_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && halted_reg) |=> !out_res_reg.byte_valid)
        else $error("byte emitted after halt");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_item.last) |=> (phase_reg == b64d_pkg::PH_0 && !halted_reg
                                    && len_reg == 2'd0 && count_reg == '0))
        else $error("string state not cleared after final character");

    a_bad_len_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_res_reg.done_res
         && out_res_reg.status == b64d_pkg::STAT_BAD_LENGTH)
        |-> (out_res_reg.decoded_count == '0))
        else $error("bad length result carries a nonzero count");

    a_status_only_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_res_reg.done_res)
        |-> (out_res_reg.status == b64d_pkg::STAT_OK && out_res_reg.decoded_count == '0))
        else $error("status reported on a non-final character");

endmodule

// ===== rtl/base64_stream_decoder.sv =====
// Top level of the base64 stream decoder: front end, queue and back end.
// Depends on b64d_pkg, b64d_front, b64d_queue and b64d_back.
//
// Decodes one base64 character (standard alphabet) per beat and returns
// exactly one result beat per character. The block accepts one character
// every clock cycle as long as the result side keeps up; an accepted
// character is written into the two-entry queue, and its result is
// registered when the queue hands it to the back end. The sustained rate
// of one beat per cycle is set by the combinational lookup in the front
// end and the quartet sequencer in the back end. A result with tuser set
// carries a decoded byte; the result with tlast set belongs to the final
// character and holds the string status and byte count. On a bad_length
// status the bytes already delivered for that string must be discarded by
// the consumer. The byte count saturates at the smaller of MAX_CHARS/4*3
// and 65535.
module base64_stream_decoder #(
    parameter int unsigned MAX_CHARS = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    input  logic        s_tlast,   // last_char
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] out_byte, [9:8] status, [25:10] decoded_count
    output logic        m_tuser,   // byte_valid
    output logic        m_tlast    // done_res
);

    localparam longint unsigned RAW_CAP = (longint'(MAX_CHARS) / 4) * 3;
    localparam logic [15:0] BYTE_CAP = (RAW_CAP > 65535) ? 16'hFFFF : 16'(RAW_CAP);

    logic                   q_full, q_empty, q_push, q_pop;
    b64d_pkg::b64d_item_t   push_item, pop_item;
    b64d_pkg::b64d_result_t res;

    b64d_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    b64d_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    b64d_back #(
        .BYTE_CAP (BYTE_CAP)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_item    (pop_item),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {6'd0, res.decoded_count, res.status, res.out_byte};
    assign m_tuser = res.byte_valid;
    assign m_tlast = res.done_res;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for base64_stream_decoder: drives encoded characters as
// beats and compares every result beat with a built-in decoder model.
// Depends on b64d_pkg and the RTL of base64_stream_decoder.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [7:0] char_q_t[$];

    // Default MAX_CHARS of 65536 caps the count at 65536 / 4 * 3 bytes.
    localparam int unsigned BYTE_CAP   = 49152;
    localparam int unsigned STALL_LIMIT = 5000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    // Decoder model state.
    b64d_pkg::b64d_phase_t  phase = b64d_pkg::PH_0;
    logic [5:0]   held_sextet = '0;
    logic         halted = 1'b0;
    logic         short_seen = 1'b0;
    logic [1:0]   length_mod_four = '0;
    logic [15:0]  byte_count = '0;

    b64d_pkg::b64d_result_t pending_results[$];
    int unsigned  errors_seen = 0;
    int unsigned  quiet_cycles = 0;
    logic         no_gaps = 1'b0;

    base64_stream_decoder u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Decodes one character into the expected result and advances the model.
    function automatic b64d_pkg::b64d_result_t predict_char(input logic [7:0] c,
                                                            input logic last);
        b64d_pkg::b64d_result_t r;
        logic [5:0]   v;
        logic         bad;
        logic         is_pad;
        r      = '0;
        v      = '0;
        bad    = 1'b0;
        is_pad = (c == b64d_pkg::PAD_CHAR);
        if (c >= 8'd65 && c <= 8'd90) begin
            v = 6'(c - 8'd65);
        end else if (c >= 8'd97 && c <= 8'd122) begin
            v = 6'(c - 8'd97 + 8'd26);
        end else if (c >= 8'd48 && c <= 8'd57) begin
            v = 6'(c - 8'd48 + 8'd52);
        end else if (c == 8'd43) begin
            v = 6'd62;
        end else if (c == 8'd47) begin
            v = 6'd63;
        end else begin
            bad = 1'b1;
        end

        if (!halted) begin
            case (phase)
                b64d_pkg::PH_1: begin
                    if (bad) begin
                        halted = 1'b1;
                        short_seen = 1'b1;
                    end else begin
                        r.out_byte = {held_sextet, v[5:4]};
                        r.byte_valid = 1'b1;
                        held_sextet = v;
                        phase = b64d_pkg::PH_2;
                    end
                end
                b64d_pkg::PH_2: begin
                    if (is_pad) begin
                        phase = b64d_pkg::PH_PAD;
                    end else if (bad) begin
                        halted = 1'b1;
                        short_seen = 1'b1;
                    end else begin
                        r.out_byte = {held_sextet[3:0], v[5:2]};
                        r.byte_valid = 1'b1;
                        held_sextet = v;
                        phase = b64d_pkg::PH_3;
                    end
                end
                b64d_pkg::PH_3: begin
                    // A pad or a bad character here ends the string; only a final one is clean.
                    if (is_pad || bad) begin
                        halted = 1'b1;
                        if (!last) short_seen = 1'b1;
                    end else begin
                        r.out_byte = {held_sextet[1:0], v};
                        r.byte_valid = 1'b1;
                        phase = b64d_pkg::PH_0;
                    end
                end
                b64d_pkg::PH_PAD: begin
                    halted = 1'b1;
                    if (!is_pad || !last) short_seen = 1'b1;
                end
                default: begin
                    if (bad) begin
                        halted = 1'b1;
                        short_seen = 1'b1;
                    end else begin
                        held_sextet = v;
                        phase = b64d_pkg::PH_1;
                    end
                end
            endcase
        end

        length_mod_four = length_mod_four + 2'd1;
        if (r.byte_valid && byte_count < BYTE_CAP) byte_count = byte_count + 16'd1;

        if (last) begin
            r.done_res = 1'b1;
            if (length_mod_four != 2'd0) begin
                r.status = b64d_pkg::STAT_BAD_LENGTH;
            end else begin
                r.status = short_seen ? b64d_pkg::STAT_SHORT : b64d_pkg::STAT_OK;
                r.decoded_count = byte_count;
            end
            phase = b64d_pkg::PH_0;
            held_sextet = '0;
            halted = 1'b0;
            short_seen = 1'b0;
            length_mod_four = '0;
            byte_count = '0;
        end
        return r;
    endfunction

    function automatic logic [7:0] rand_alpha_char();
        int unsigned k;
        k = $urandom_range(63);
        if (k < 26) return 8'(65 + k);
        if (k < 52) return 8'(97 + k - 26);
        if (k < 62) return 8'(48 + k - 52);
        return (k == 62) ? 8'd43 : 8'd47;
    endfunction

    task automatic send_char(input logic [7:0] c, input logic last);
        @(negedge aclk);
        while (!no_gaps && $urandom_range(99) < 32) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom_range(255));
            s_tlast  <= 1'($urandom_range(1));
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(predict_char(c, last));
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) send_char(txt[i], i == txt.len() - 1);
    endtask

    task automatic test_alphabet_edges();
        // Both ends of every alphabet range in two full quartets.
        send_text("Az9/Za0+");
    endtask

    task automatic test_special_cases();
        // Pad in position three followed by a data character.
        send_text("QQ=A");
        // Pad pair mid-string: the rest is swallowed and the string is short.
        send_text("QQ==AAAA");
        // A three-character string, then an invalid character alone as a final string; both have a bad length.
        send_text("AAA");
        send_char(8'h80, 1'b1);
        // Halt in position one on 0xFF, then 0x00, a pad and a final A are swallowed.
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(b64d_pkg::PAD_CHAR, 1'b0);
        send_char(8'd65, 1'b1);
        // Length not a multiple of four.
        send_char(8'd65, 1'b0);
        send_char(8'h7F, 1'b1);
    endtask

    task automatic test_random_strings();
        char_q_t     s;
        int unsigned chars_sent;
        int unsigned kind;
        int unsigned extra;
        chars_sent = 0;
        while (chars_sent < 1500) begin
            s.delete();
            repeat (4 * $urandom_range(6, 1)) s.push_back(rand_alpha_char());
            kind = $urandom_range(99);
            if (kind < 60) begin
                case ($urandom_range(2))
                    1: s[$] = b64d_pkg::PAD_CHAR;
                    2: begin
                        s[$] = b64d_pkg::PAD_CHAR;
                        s[$-1] = b64d_pkg::PAD_CHAR;
                    end
                    default: ;
                endcase
            end else if (kind < 80) begin
                repeat ($urandom_range(2, 1))
                    s[$urandom_range(s.size() - 1)] = 8'($urandom_range(255));
            end else if (kind < 90) begin
                s[$urandom_range(s.size() - 1)] = b64d_pkg::PAD_CHAR;
            end else begin
                extra = $urandom_range(3, 1);
                if ($urandom_range(1)) begin
                    repeat (extra) s.push_back(rand_alpha_char());
                end else begin
                    repeat (extra) void'(s.pop_back());
                end
            end
            foreach (s[i]) send_char(s[i], i == s.size() - 1);
            chars_sent += s.size();
        end
    endtask

    task automatic test_no_gap_run();
        int unsigned n;
        // One long string sent with no idling on either side.
        n = 256;
        no_gaps = 1'b1;
        for (int unsigned i = 0; i < n; i++) send_char(rand_alpha_char(), i == n - 1);
        no_gaps = 1'b0;
    endtask

    always @(negedge aclk) begin
        m_tready <= aresetn && (no_gaps || $urandom_range(99) >= 32);
    end

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            errors_seen++;
        end
    endtask

    always @(posedge aclk) begin
        b64d_pkg::b64d_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no character waiting for it");
                errors_seen++;
            end else begin
                want = pending_results.pop_front();
                check_field("out_byte", want.out_byte, m_tdata[7:0]);
                check_field("status", want.status, m_tdata[9:8]);
                check_field("decoded_count", want.decoded_count, m_tdata[25:10]);
                check_field("tdata padding", 0, m_tdata[31:26]);
                check_field("byte_valid", want.byte_valid, m_tuser);
                check_field("done_res", want.done_res, m_tlast);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        test_alphabet_edges();
        test_special_cases();
        test_random_strings();
        test_no_gap_run();

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (errors_seen == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
